// ===== hdl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants for the softmax row backward block
// Word layouts, row store geometry and datapath widths.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int ROW_MAX   = 64;
    localparam int ADDR_W    = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int CNT_W     = $clog2(ROW_MAX + 1);

    localparam int PROB_W    = 16;
    localparam int GRAD_W    = 16;
    localparam int WORD_W    = PROB_W + GRAD_W;   // store word {prob, grad}
    localparam int FRAC_P    = 15;                // Q1.15 fraction bits
    localparam int DOT_W     = 38;                // Q12.26 accumulator
    localparam int DIFF_W    = DOT_W + 1;
    localparam int MUL_B_W   = PROB_W + 1;        // prob as signed operand
    localparam int PROD_W    = DIFF_W + MUL_B_W;
    localparam int RND_SHIFT = 30;                // Q.41 -> Q.11
    localparam int Q_W       = PROD_W - RND_SHIFT;
    localparam int RES_W     = 16;

    typedef struct packed {
        logic        [PROB_W-1:0] prob_value;
        logic signed [GRAD_W-1:0] grad_value;
        logic                     row_end;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic                    result_end;
        logic                    row_overflow;
    } t_out;

endpackage

// ===== hdl/softmax_row_backward.sv =====
// ----------------------------------------------------------------------------
// softmax_row_backward: softmax gradient (Jacobian-vector product) for a row
// Each input word is taken in IDLE and folded into dot in ACC, where busy is high.
// After the row-end word, the results strobe in store order, each one walking
// RD -> DIFF -> MUL -> OUT: single shared multiplier, one store read each.
// busy drops with the last strobe. Synchronous active-low reset clears the
// sequencer, count, accumulator and overflow flag. Results cannot be stalled.
// ----------------------------------------------------------------------------
module softmax_row_backward (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  srb_pkg::t_in  i_data,
    output logic          o_valid,
    output srb_pkg::t_out o_result
);

    // Sequencer: IDLE takes a word and runs the shared multiplier on it,
    // ACC folds the product into dot. Emit walks RD -> DIFF -> MUL -> OUT
    // once per stored element.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_RD   = 6'b000100,
        S_DIFF = 6'b001000,
        S_MUL  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [srb_pkg::CNT_W-1:0]         r_count, n_count;
    logic [srb_pkg::CNT_W-1:0]         r_idx, n_idx;
    logic signed [srb_pkg::DOT_W-1:0]  r_dot, n_dot;
    logic                              r_ovf, n_ovf;
    logic                              r_keep, n_keep;   // word was stored
    logic                              r_end, n_end;     // word closed the row
    logic signed [srb_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [srb_pkg::DIFF_W-1:0] r_diff, n_diff;
    logic [srb_pkg::PROB_W-1:0]        r_eprob, n_eprob;
    logic                              r_valid, n_valid;
    srb_pkg::t_out                     r_result, n_result;

    // Row store
    logic                       ram_we;
    logic                       ram_re;
    logic [srb_pkg::WORD_W-1:0] ram_rdata;

    srb_ram #(
        .WIDTH (srb_pkg::WORD_W),
        .DEPTH (srb_pkg::ROW_MAX)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[srb_pkg::ADDR_W-1:0]),
        .i_wdata ({i_data.prob_value, i_data.grad_value}),
        .i_re    (ram_re),
        .i_raddr (r_idx[srb_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Shared multiplier: prob*grad while loading, (grad<<15 - dot)*prob on emit
    logic signed [srb_pkg::DIFF_W-1:0]  mul_a;
    logic signed [srb_pkg::MUL_B_W-1:0] mul_b;
    logic signed [srb_pkg::PROD_W-1:0]  mul_p;

    always_comb begin
        if (r_state == S_IDLE) begin
            mul_a = srb_pkg::DIFF_W'(i_data.grad_value);
            mul_b = $signed({1'b0, i_data.prob_value});
        end else begin
            mul_a = r_diff;
            mul_b = $signed({1'b0, r_eprob});
        end
    end

    assign mul_p = mul_a * mul_b;

    // Emit datapath helpers
    logic signed [srb_pkg::GRAD_W-1:0] e_grad;
    logic signed [srb_pkg::DIFF_W-1:0] e_grad_al;
    logic signed [srb_pkg::PROD_W-1:0] rnd_sum;
    logic signed [srb_pkg::Q_W-1:0]    rnd_q;
    logic signed [srb_pkg::RES_W-1:0]  sat_q;
    logic                              sat_hi, sat_lo;
    logic [srb_pkg::CNT_W-1:0]         cnt_after;
    logic                              idx_last;

    assign e_grad    = $signed(ram_rdata[srb_pkg::GRAD_W-1:0]);
    // grad aligned to Q.26
    assign e_grad_al = $signed({{(srb_pkg::DIFF_W - srb_pkg::GRAD_W - srb_pkg::FRAC_P)
                                  {e_grad[srb_pkg::GRAD_W-1]}},
                                e_grad, {srb_pkg::FRAC_P{1'b0}}});

    // round half up: add half an LSB, then arithmetic shift (floor)
    assign rnd_sum = r_prod + (srb_pkg::PROD_W'(1) <<< (srb_pkg::RND_SHIFT - 1));
    assign rnd_q   = rnd_sum[srb_pkg::PROD_W-1:srb_pkg::RND_SHIFT];
    assign sat_hi  = !rnd_q[srb_pkg::Q_W-1] &&  (|rnd_q[srb_pkg::Q_W-2:srb_pkg::RES_W-1]);
    assign sat_lo  =  rnd_q[srb_pkg::Q_W-1] && !(&rnd_q[srb_pkg::Q_W-2:srb_pkg::RES_W-1]);

    always_comb begin
        priority if (sat_hi) begin
            sat_q = {1'b0, {(srb_pkg::RES_W-1){1'b1}}};
        end else if (sat_lo) begin
            sat_q = {1'b1, {(srb_pkg::RES_W-1){1'b0}}};
        end else begin
            sat_q = rnd_q[srb_pkg::RES_W-1:0];
        end
    end

    assign cnt_after = r_keep ? (r_count + srb_pkg::CNT_W'(1)) : r_count;
    assign idx_last  = ({1'b0, r_idx} + (srb_pkg::CNT_W + 1)'(1)) == {1'b0, r_count};

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_dot    = r_dot;
        n_ovf    = r_ovf;
        n_keep   = r_keep;
        n_end    = r_end;
        n_prod   = r_prod;
        n_diff   = r_diff;
        n_eprob  = r_eprob;
        n_valid  = 1'b0;
        n_result = r_result;
        ram_we   = 1'b0;
        ram_re   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_prod = mul_p;
                    n_end  = i_data.row_end;
                    // full store: drop the word, flag the row
                    if (r_count != srb_pkg::CNT_W'(srb_pkg::ROW_MAX)) begin
                        n_keep = 1'b1;
                        ram_we = 1'b1;
                    end else begin
                        n_keep = 1'b0;
                        n_ovf  = 1'b1;
                    end
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_keep) begin
                    n_dot = r_dot + r_prod[srb_pkg::DOT_W-1:0];
                end
                n_count = cnt_after;
                n_idx   = '0;
                if (!r_end) begin
                    n_state = S_IDLE;
                end else if (cnt_after == '0) begin
                    // empty row: nothing to emit
                    n_dot   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_diff  = e_grad_al - srb_pkg::DIFF_W'(r_dot);
                n_eprob = ram_rdata[srb_pkg::WORD_W-1:srb_pkg::GRAD_W];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_valid                = 1'b1;
                n_result.result_value  = sat_q;
                n_result.result_end    = idx_last;
                n_result.row_overflow  = r_ovf;
                if (idx_last) begin
                    n_dot   = '0;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + srb_pkg::CNT_W'(1);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_dot   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_dot   <= n_dot;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_keep   <= n_keep;
        r_end    <= n_end;
        r_prod   <= n_prod;
        r_diff   <= n_diff;
        r_eprob  <= n_eprob;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/srb_ram.sv =====
// ----------------------------------------------------------------------------
// srb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/srb_checker.sv =====
// ----------------------------------------------------------------------------
// srb_checker: input-gradient predictor and scoreboard for softmax_row_backward
// Watches accepted words and result strobes, replays the row arithmetic and
// compares each strobed result with the oldest predicted gradient.
// ----------------------------------------------------------------------------
module srb_checker
    import srb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_word,
    input  logic i_valid,
    input  t_out i_result,
    output int   o_mismatches,
    output int   o_waiting
);

    logic        [PROB_W-1:0] prob_mem [ROW_MAX];
    logic signed [GRAD_W-1:0] grad_mem [ROW_MAX];
    longint                   dot_sum;
    int                       n_stored;
    bit                       dropped_any;
    t_out                     input_grad_q [$];
    int                       n_bad;

    initial begin
        o_mismatches = 0;
        o_waiting    = 0;
        n_bad        = 0;
        dot_sum      = 0;
        n_stored     = 0;
        dropped_any  = 1'b0;
    end

    // prob * (grad - dot) in Q.41, rounded half up to Q4.11 and saturated
    function automatic logic signed [RES_W-1:0] jvp_result(
        input logic [PROB_W-1:0] p, input logic signed [GRAD_W-1:0] g, input longint dot
    );
        longint diff;
        longint q;
        diff = longint'(g) * 32768 - dot;
        q    = (diff * longint'(p) + (64'sd1 <<< 29)) >>> RND_SHIFT;
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return q[RES_W-1:0];
    endfunction

    task automatic absorb_element(input t_in w);
        t_out r;
        if (n_stored < ROW_MAX) begin
            prob_mem[n_stored] = w.prob_value;
            grad_mem[n_stored] = w.grad_value;
            dot_sum  += longint'(w.prob_value) * longint'(w.grad_value);
            n_stored++;
        end else begin
            dropped_any = 1'b1;     // full store: word dropped, row still ends
        end
        if (w.row_end) begin
            for (int i = 0; i < n_stored; i++) begin
                r.result_value = jvp_result(prob_mem[i], grad_mem[i], dot_sum);
                r.result_end   = (i == n_stored - 1);
                r.row_overflow = dropped_any;
                input_grad_q.insert(input_grad_q.size(), r);
            end
            dot_sum     = 0;
            n_stored    = 0;
            dropped_any = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            dot_sum     = 0;
            n_stored    = 0;
            dropped_any = 1'b0;
            input_grad_q.delete();
        end else begin
            if (i_valid) begin
                if (input_grad_q.size() == 0) begin
                    if (n_bad < 10)
                        $display("unexpected result: value %0d end %0b ovf %0b",
                                 i_result.result_value, i_result.result_end,
                                 i_result.row_overflow);
                    n_bad++;
                end else begin
                    want = input_grad_q.pop_front();
                    if (i_result !== want) begin
                        if (n_bad < 10)
                            $display("mismatch: exp value %0d end %0b ovf %0b, got value %0d end %0b ovf %0b",
                                     want.result_value, want.result_end, want.row_overflow,
                                     i_result.result_value, i_result.result_end,
                                     i_result.row_overflow);
                        n_bad++;
                    end
                end
            end
            if (i_start && !i_busy)
                absorb_element(i_word);
        end
        o_mismatches <= n_bad;
        o_waiting    <= input_grad_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for softmax_row_backward
// Drives rows of {prob, grad} words with random gaps, directed corner rows
// first, then random rows including full and overflowing ones. srb_checker
// predicts and compares every strobed result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import srb_pkg::*;

    localparam int RANDOM_WORDS = 250;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_data  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    int   mismatches;
    int   waiting;
    int   words_sent = 0;
    int   cycles     = 0;
    bit   no_gaps    = 1'b0;    // set per row to get back-to-back stretches

    softmax_row_backward dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    srb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_word       (i_data),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one word and hold it until accepted. Start stays high across
    // back-to-back words; a gap lowers it once and raises it in a later step.
    task automatic push_word(input t_in w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // Hold off until every predicted result has been strobed
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
    endtask

    task automatic push_pair(input logic [15:0] p, input logic [15:0] g, input bit last);
        t_in w;
        w.prob_value = p;
        w.grad_value = g;
        w.row_end    = last;
        push_word(w);
    endtask

    // Mostly in-range probabilities, with the ends, tiny values and
    // values above one mixed in
    function automatic logic [15:0] pick_prob();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(32769, 65535));
            4, 5:    return 16'($urandom_range(0, 2047));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_grad();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3, 4:    return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_random_row(input int len);
        for (int i = 0; i < len; i++)
            push_pair(pick_prob(), pick_grad(), i == len - 1);
    endtask

    initial begin
        int row_len;
        int row_idx;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: field extremes, prob above one, saturation both ways
        push_pair(16'd0,     16'h0000, 1'b1);
        push_pair(16'd32768, 16'h8000, 1'b1);
        push_pair(16'hFFFF,  16'h7FFF, 1'b1);
        push_pair(16'hFFFF,  16'h8000, 1'b0);
        push_pair(16'hFFFF,  16'h7FFF, 1'b1);
        drain_results();
        push_pair(16'd16384, 16'd2048, 1'b0);
        push_pair(16'd16384, -16'sd2048, 1'b0);
        push_pair(16'd16384, 16'd1024, 1'b1);
        push_pair(16'h5555,  16'hAAAA, 1'b0);
        push_pair(16'hAAAA,  16'h5555, 1'b0);
        push_pair(16'd1,     16'd1,    1'b1);
        drain_results();

        // Random rows; two full rows, one overflowing so that its row-end word is dropped
        words_sent = 0;
        row_idx    = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (row_idx == 2)
                row_len = ROW_MAX + 1;          // row-end word lands on a full store
            else if (row_idx == 7)
                row_len = ROW_MAX;              // exactly full, no overflow
            else if ($urandom_range(0, 6) == 0)
                row_len = $urandom_range(9, 24);
            else
                row_len = $urandom_range(1, 8);
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                drain_results();
            push_random_row(row_len);
            row_idx++;
        end

        drain_results();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && waiting == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/srb_pkg.sv
hdl/srb_ram.sv
hdl/softmax_row_backward.sv
bench/srb_checker.sv
bench/tb_top.sv
